// ----- rtl/biquad_lowpass_interleaved_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the interleaved biquad low-pass filter
// Each macro writes one labeled concurrent assertion, sampled on the rising
// clock edge and disabled while reset is active.
// ----------------------------------------------------------------------------
`ifndef BIQUAD_LOWPASS_INTERLEAVED_DEFINES_SVH
`define BIQUAD_LOWPASS_INTERLEAVED_DEFINES_SVH

// same-cycle implication
`define BQLI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bqli assertion failed");

// next-cycle implication
`define BQLI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bqli assertion failed");

`endif

// ----- rtl/bqli_pkg.sv -----
// ----------------------------------------------------------------------------
// bqli_pkg
// Types and constants shared by the interleaved biquad low-pass filter.
// ----------------------------------------------------------------------------
package bqli_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 32;
  localparam int FRAC_W    = 28;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_CH_W  = 2;

  localparam logic [NUM_CH_W-1:0]      NUM_CH_RST = 2'd1;
  localparam logic signed [COEF_W-1:0] COEF_ONE   = 32'sh1000_0000;
  localparam logic signed [COEF_W-1:0] COEF_ZERO  = 32'sh0000_0000;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_word_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_CH = 3'd0,
    REG_A1     = 3'd1,
    REG_A2     = 3'd2,
    REG_A3     = 3'd3,
    REG_B1     = 3'd4,
    REG_B2     = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    coef_word_t a1;
    coef_word_t a2;
    coef_word_t a3;
    coef_word_t b1;
    coef_word_t b2;
  } coef_t;

  typedef struct packed {
    sample_t x1;
    sample_t x2;
    sample_t y1;
    sample_t y2;
  } hist_t;

endpackage

// ----- rtl/bqli_if.sv -----
// ----------------------------------------------------------------------------
// bqli_if
// Valid/ready channels of the interleaved biquad low-pass filter: sample
// input, filtered output and register write.
// ----------------------------------------------------------------------------
interface bqli_in_if
  import bqli_pkg::*;
();
  logic    valid;
  logic    ready;
  sample_t sample_in;
  logic    start_req;

  modport source (output valid, output sample_in, output start_req, input ready);
  modport sink   (input valid, input sample_in, input start_req, output ready);
endinterface

interface bqli_out_if
  import bqli_pkg::*;
();
  logic    valid;
  logic    ready;
  sample_t sample_out;
  logic    channel;

  modport source (output valid, output sample_out, output channel, input ready);
  modport sink   (input valid, input sample_out, input channel, output ready);
endinterface

interface bqli_cfg_if
  import bqli_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COEF_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/bqli_cfg.sv -----
// ----------------------------------------------------------------------------
// bqli_cfg
// Register file for channel count and the five Q3.28 filter coefficients.
// ----------------------------------------------------------------------------
module bqli_cfg
  import bqli_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  bqli_cfg_if.sink            cfg,
  output logic [NUM_CH_W-1:0] num_ch,
  output coef_t               coef
);

  logic [NUM_CH_W-1:0] num_ch_r;
  coef_t               coef_r;
  cfg_idx_t            idx;

  assign cfg.ready = 1'b1;
  assign idx       = cfg_idx_t'(cfg.index);
  assign num_ch    = num_ch_r;
  assign coef      = coef_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_ch_r  <= NUM_CH_RST;
      coef_r.a1 <= COEF_ONE;
      coef_r.a2 <= COEF_ZERO;
      coef_r.a3 <= COEF_ZERO;
      coef_r.b1 <= COEF_ZERO;
      coef_r.b2 <= COEF_ZERO;
    end else if (cfg.valid) begin
      unique case (idx)
        REG_NUM_CH: num_ch_r  <= cfg.data[NUM_CH_W-1:0];
        REG_A1:     coef_r.a1 <= cfg.data;
        REG_A2:     coef_r.a2 <= cfg.data;
        REG_A3:     coef_r.a3 <= cfg.data;
        REG_B1:     coef_r.b1 <= cfg.data;
        REG_B2:     coef_r.b2 <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/bqli_hist.sv -----
// ----------------------------------------------------------------------------
// bqli_hist
// Per-channel sample and output history with the interleave channel counter.
// ----------------------------------------------------------------------------
module bqli_hist
  import bqli_pkg::*;
#(
  parameter int CHANNELS = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic                start,
  input  logic [NUM_CH_W-1:0] num_ch,
  input  sample_t             x,
  input  sample_t             y,
  output hist_t               hist,
  output logic                channel
);

  localparam int CNT_W = $clog2(CHANNELS + 1);
  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  hist_t            hist_r [CHANNELS];
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [CNT_W-1:0] nch;
  logic [CNT_W-1:0] cnt_base;
  logic [CNT_W-1:0] ch_sel;
  logic [CNT_W-1:0] ch_inc;
  hist_t            rd;

  always_comb begin
    priority if (num_ch == '0) begin
      nch = CNT_W'(1);
    end else if (32'(num_ch) > CHANNELS) begin
      nch = CNT_W'(CHANNELS);
    end else begin
      nch = CNT_W'(num_ch);
    end
    cnt_base = start ? '0 : cnt_r;
    ch_sel   = (cnt_base >= nch) ? '0 : cnt_base;
    ch_inc   = ch_sel + CNT_W'(1);
    cnt_nxt  = (ch_inc >= nch) ? '0 : ch_inc;
    rd       = hist_r[ch_sel[IDX_W-1:0]];
    hist     = start ? '0 : rd;
  end

  assign channel = ch_sel[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (fire) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        hist_r[c] <= '0;
      end
    end else if (fire) begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (IDX_W'(c) == ch_sel[IDX_W-1:0]) begin
          hist_r[c].x1 <= x;
          hist_r[c].x2 <= hist.x1;
          hist_r[c].y1 <= y;
          hist_r[c].y2 <= hist.y1;
        end else if (start) begin
          hist_r[c] <= '0;
        end
      end
    end
  end

endmodule

// ----- rtl/bqli_mac.sv -----
// ----------------------------------------------------------------------------
// bqli_mac
// Five products, the a terms added and the b terms subtracted, scaled by
// 2^-28 toward zero and saturated to 16 bits.
// ----------------------------------------------------------------------------
module bqli_mac
  import bqli_pkg::*;
(
  input  sample_t x,
  input  hist_t   hist,
  input  coef_t   coef,
  output sample_t y
);

  localparam int PROD_W = COEF_W + SAMPLE_W;
  localparam int ACC_W  = PROD_W + 3;
  localparam int Q_W    = ACC_W - FRAC_W;

  logic signed [PROD_W-1:0] p_a1, p_a2, p_a3, p_b1, p_b2;
  logic signed [ACC_W-1:0]  acc;
  logic signed [Q_W-1:0]    q;
  logic signed [Q_W-1:0]    qt;
  logic                     frac_nz;

  always_comb begin
    p_a1    = PROD_W'(coef.a1) * PROD_W'(x);
    p_a2    = PROD_W'(coef.a2) * PROD_W'(hist.x1);
    p_a3    = PROD_W'(coef.a3) * PROD_W'(hist.x2);
    p_b1    = PROD_W'(coef.b1) * PROD_W'(hist.y1);
    p_b2    = PROD_W'(coef.b2) * PROD_W'(hist.y2);
    acc     = ACC_W'(p_a1) + ACC_W'(p_a2) + ACC_W'(p_a3)
            - ACC_W'(p_b1) - ACC_W'(p_b2);
    q       = acc[ACC_W-1:FRAC_W];
    frac_nz = |acc[FRAC_W-1:0];
    qt      = q + Q_W'(acc[ACC_W-1] && frac_nz);
    priority if (qt > Q_W'(SAMPLE_MAX)) begin
      y = SAMPLE_MAX;
    end else if (qt < Q_W'(SAMPLE_MIN)) begin
      y = SAMPLE_MIN;
    end else begin
      y = qt[SAMPLE_W-1:0];
    end
  end

endmodule

// ----- rtl/biquad_lowpass_interleaved.sv -----
// ----------------------------------------------------------------------------
// biquad_lowpass_interleaved
// Second-order IIR low-pass filter over interleaved 16-bit PCM, one history
// per channel.
//
// in_ch takes one sample per word with start_req marking a new stream;
// out_ch returns one filtered sample per input word with the low bit of its channel index;
// cfg_ch writes the channel count and the Q3.28 coefficients, always ready;
// it must be written only while no sample is in flight; the block does not check.
// The input register takes the word; the multiply-sum and the history update
// then run from it into the output register.
// Throughput is one word per cycle while out_ch does not stall; a sample's own
// channel history is updated in the same cycle its result is registered.
// After reset the history and channel counter are zero, one channel is set
// and coefficient a1 is 1.0. When out_ch stalls the output register holds,
// the input register fills, and in_ch.ready drops until out_ch drains.
// ----------------------------------------------------------------------------
module biquad_lowpass_interleaved
  import bqli_pkg::*;
#(
  parameter int CHANNELS = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  bqli_in_if.sink     in_ch,
  bqli_out_if.source  out_ch,
  bqli_cfg_if.sink    cfg_ch
);

  logic                s_v_r;
  sample_t             x_r;
  logic                start_r;
  logic                o_v_r;
  sample_t             y_r;
  logic                ch_r;
  logic                fire;
  logic [NUM_CH_W-1:0] num_ch;
  coef_t               coef;
  hist_t               hist;
  sample_t             y;
  logic                channel;

  assign fire        = s_v_r && (!o_v_r || out_ch.ready);
  assign in_ch.ready = !s_v_r || fire;

  assign out_ch.valid      = o_v_r;
  assign out_ch.sample_out = y_r;
  assign out_ch.channel    = ch_r;

  bqli_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_ch),
    .num_ch (num_ch),
    .coef   (coef)
  );

  bqli_hist #(
    .CHANNELS (CHANNELS)
  ) u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .start   (start_r),
    .num_ch  (num_ch),
    .x       (x_r),
    .y       (y),
    .hist    (hist),
    .channel (channel)
  );

  bqli_mac u_mac (
    .x    (x_r),
    .hist (hist),
    .coef (coef),
    .y    (y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      s_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      x_r     <= in_ch.sample_in;
      start_r <= in_ch.start_req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (fire) begin
      o_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      o_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      y_r  <= y;
      ch_r <= channel;
    end
  end

endmodule

// ----- rtl/bqli_chk.sv -----
// ----------------------------------------------------------------------------
// bqli_chk
// Port-level checks for the interleaved biquad low-pass filter.
// ----------------------------------------------------------------------------
`include "biquad_lowpass_interleaved_defines.svh"

module bqli_chk
  import bqli_pkg::*;
(
  input logic    clk,
  input logic    rst_n,
  input logic    in_valid,
  input logic    in_ready,
  input logic    in_start_req,
  input logic    out_valid,
  input logic    out_ready,
  input sample_t out_sample_out,
  input logic    out_channel
);

  `BQLI_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_sample_out) && $stable(out_channel))

  `BQLI_ASSERT_IMPL(a_in_open, clk, rst_n, !out_valid, in_ready)

  `BQLI_ASSERT_NEXT(a_start_ch0, clk, rst_n, (in_valid && in_ready && in_start_req) ##1 (!out_valid || out_ready), out_valid && !out_channel)

endmodule

bind biquad_lowpass_interleaved bqli_chk u_bqli_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_start_req   (in_ch.start_req),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_sample_out (out_ch.sample_out),
  .out_channel    (out_ch.channel)
);
